FILE: hw/rtl/hrc_pkg.sv
package hrc_pkg;

    localparam int TEMP_W  = 14;
    localparam int GOAL_W  = 15;
    localparam int WIDE_W  = 16;
    localparam int TIME_W  = 32;
    localparam int ERR_W   = 32;
    localparam int HYST_W  = 11;
    localparam int MAXE_W  = 20;
    localparam int GAIN_W  = 11;
    localparam int CGT_W   = 20;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 20;
    localparam int IN_DW   = 64;
    localparam int OUT_DW  = 8;
    localparam int DELAY_W = 2;

    localparam logic [CFG_AW-1:0] CFG_HYSTERESIS  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ERR_LIMIT   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_RISE_STEP   = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_RISE_WINDOW = 2'd3;

    localparam logic [HYST_W-1:0] HYST_RST = 11'd80;
    localparam logic [MAXE_W-1:0] MAXE_RST = 20'd1920;
    localparam logic [GAIN_W-1:0] GAIN_RST = 11'd32;
    localparam logic [CGT_W-1:0]  CGT_RST  = 20'd20000;

    localparam logic [DELAY_W-1:0] DELAY_NORMAL = 2'd1;
    localparam logic [DELAY_W-1:0] DELAY_FAULT  = 2'd2;

    typedef struct packed {
        logic [HYST_W-1:0] hysteresis;
        logic [MAXE_W-1:0] err_limit;
        logic [GAIN_W-1:0] rise_step;
        logic [CGT_W-1:0]  rise_window;
    } t_cfg;

    typedef struct packed {
        logic                     approach;
        logic                     starting;
        logic signed [TEMP_W-1:0] prev_target;
        logic signed [GOAL_W-1:0] goal_level;
        logic [TIME_W-1:0]        goal_time;
        logic [ERR_W-1:0]         err;
        logic                     fault;
    } t_state;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic signed [TEMP_W-1:0] target;
        logic [TIME_W-1:0]        time_ms;
    } t_sample;

    typedef struct packed {
        logic               fault_active;
        logic               fault_raised;
        logic               fault_cleared;
        logic               approaching;
        logic [DELAY_W-1:0] next_delay_s;
    } t_result;

endpackage

FILE: hw/rtl/hrc_step.sv
module hrc_step (
    input  hrc_pkg::t_cfg    i_cfg,
    input  hrc_pkg::t_state  i_state,
    input  hrc_pkg::t_sample i_sample,
    output hrc_pkg::t_state  o_state,
    output hrc_pkg::t_result o_result
);

    logic signed [hrc_pkg::WIDE_W-1:0] temp_x;
    logic signed [hrc_pkg::WIDE_W-1:0] tgt_x;
    logic signed [hrc_pkg::WIDE_W-1:0] hy_x;
    logic signed [hrc_pkg::WIDE_W-1:0] tgt_lo;
    logic signed [hrc_pkg::WIDE_W-1:0] tgt_hi;
    logic signed [hrc_pkg::WIDE_W-1:0] shortfall;
    logic signed [hrc_pkg::WIDE_W-1:0] goal_x;
    logic signed [hrc_pkg::GOAL_W-1:0] temp_gain;
    logic [hrc_pkg::ERR_W:0]           sum;
    logic [hrc_pkg::ERR_W-1:0]         err_sat;
    logic [hrc_pkg::ERR_W-1:0]         max_x;
    logic [hrc_pkg::TIME_W:0]          win_sum;
    logic [hrc_pkg::TIME_W-1:0]        win_end;
    logic                              in_range;
    logic                              above;

    assign temp_x = {{2{i_sample.temperature[hrc_pkg::TEMP_W-1]}}, i_sample.temperature};
    assign tgt_x  = {{2{i_sample.target[hrc_pkg::TEMP_W-1]}}, i_sample.target};
    assign hy_x   = $signed({5'd0, i_cfg.hysteresis});
    assign tgt_lo = tgt_x - hy_x;
    assign tgt_hi = tgt_x + hy_x;
    assign goal_x = {i_state.goal_level[hrc_pkg::GOAL_W-1], i_state.goal_level};
    assign temp_gain = $signed({i_sample.temperature[hrc_pkg::TEMP_W-1], i_sample.temperature})
                     + $signed({4'd0, i_cfg.rise_step});

    assign in_range  = (temp_x >= tgt_lo) || (tgt_x <= 16'sd0);
    assign above     = temp_x > tgt_hi;

    // positive whenever the sample is below the band
    assign shortfall = tgt_lo - temp_x;
    assign sum       = {1'b0, i_state.err} + {18'd0, shortfall[14:0]};
    assign err_sat   = sum[hrc_pkg::ERR_W] ? '1 : sum[hrc_pkg::ERR_W-1:0];
    assign max_x     = {12'd0, i_cfg.err_limit};

    assign win_sum = {1'b0, i_sample.time_ms} + {13'd0, i_cfg.rise_window};
    assign win_end = win_sum[hrc_pkg::TIME_W] ? '1 : win_sum[hrc_pkg::TIME_W-1:0];

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.next_delay_s = hrc_pkg::DELAY_NORMAL;
        if (in_range) begin
            o_state.approach = 1'b0;
            o_state.starting = 1'b0;
            if (i_state.fault) begin
                o_state.fault = 1'b0;
                o_result.fault_cleared = 1'b1;
            end
            if (!above) begin
                o_state.err = '0;
            end
            o_state.prev_target = i_sample.target;
        end else begin
            o_state.err = err_sat;
            // a raising sample has target equal to previous target already
            o_state.prev_target = i_sample.target;
            if (!i_state.approach) begin
                if (i_sample.target != i_state.prev_target) begin
                    o_state.approach   = 1'b1;
                    o_state.starting   = 1'b1;
                    o_state.goal_level = temp_gain;
                    o_state.goal_time  = win_end;
                end else if (err_sat >= max_x) begin
                    if (!i_state.fault) begin
                        o_state.fault = 1'b1;
                        o_result.fault_raised = 1'b1;
                        o_result.next_delay_s = hrc_pkg::DELAY_FAULT;
                    end else begin
                        o_state.err = max_x;
                    end
                end
            end else if (temp_x >= goal_x) begin
                o_state.starting   = 1'b0;
                o_state.err        = '0;
                o_state.goal_level = temp_gain;
                o_state.goal_time  = win_end;
            end else if (i_sample.time_ms >= i_state.goal_time) begin
                o_state.approach = 1'b0;
                if (i_state.fault) begin
                    o_state.fault = 1'b0;
                    o_result.fault_cleared = 1'b1;
                end
            end else if (i_state.starting) begin
                if (temp_gain < i_state.goal_level) begin
                    o_state.goal_level = temp_gain;
                end
            end
        end
        o_result.fault_active = o_state.fault;
        o_result.approaching  = o_state.approach;
    end

endmodule

FILE: hw/rtl/heater_runaway_checker.sv
// channel | dir | handshake                 | payload
// s       | in  | i_s_tvalid / o_s_tready   | i_s_tdata: sample
// m       | out | o_m_tvalid / i_m_tready   | o_m_tdata: result
// cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_addr, i_cfg_data
//
// One sample per cycle unless a stalled sink holds a result; the result is
// registered, appearing in the cycle after the request, as does the new state.
// Sync active-low reset restores register defaults and resets checker state.
// A pending result held by a stalled sink blocks new requests only when
// the sink is not taking it in the same cycle.
module heater_runaway_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [13:0] temperature, [27:14] target, [59:28] time_ms, [63:60] zero
    input  logic [hrc_pkg::IN_DW-1:0]    i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [0] fault_active, [1] fault_raised, [2] fault_cleared, [3] approaching,
    // [5:4] next_delay_s, [7:6] zero
    output logic [hrc_pkg::OUT_DW-1:0]   o_m_tdata,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hrc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [hrc_pkg::CFG_DW-1:0]   i_cfg_data
);

    hrc_pkg::t_cfg    r_cfg;
    hrc_pkg::t_state  r_state;
    hrc_pkg::t_state  n_state;
    hrc_pkg::t_sample sample;
    hrc_pkg::t_result n_out;
    hrc_pkg::t_result r_out;
    logic             r_out_valid;
    logic             take;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;
    assign take        = i_s_tvalid && o_s_tready;

    assign sample.temperature = i_s_tdata[13:0];
    assign sample.target      = i_s_tdata[27:14];
    assign sample.time_ms     = i_s_tdata[59:28];

    hrc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_sample (sample),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hysteresis  <= hrc_pkg::HYST_RST;
            r_cfg.err_limit   <= hrc_pkg::MAXE_RST;
            r_cfg.rise_step   <= hrc_pkg::GAIN_RST;
            r_cfg.rise_window <= hrc_pkg::CGT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                hrc_pkg::CFG_HYSTERESIS: begin
                    r_cfg.hysteresis <= i_cfg_data[hrc_pkg::HYST_W-1:0];
                end
                hrc_pkg::CFG_ERR_LIMIT: begin
                    r_cfg.err_limit <= i_cfg_data[hrc_pkg::MAXE_W-1:0];
                end
                hrc_pkg::CFG_RISE_STEP: begin
                    r_cfg.rise_step <= i_cfg_data[hrc_pkg::GAIN_W-1:0];
                end
                hrc_pkg::CFG_RISE_WINDOW: begin
                    r_cfg.rise_window <= i_cfg_data[hrc_pkg::CGT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.approach    <= 1'b0;
            r_state.starting    <= 1'b0;
            r_state.prev_target <= '0;
            r_state.goal_level  <= '0;
            r_state.goal_time   <= '1;
            r_state.err         <= '0;
            r_state.fault       <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            if (take) begin
                r_state <= n_state;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.next_delay_s, r_out.approaching, r_out.fault_cleared,
                         r_out.fault_raised, r_out.fault_active};

endmodule

FILE: tb/sv/heater_runaway_checker_test.sv
`timescale 1ns / 1ps

module heater_runaway_checker_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_ITEMS   = 300;

    typedef logic signed [hrc_pkg::TEMP_W-1:0] t_temp;
    typedef logic signed [hrc_pkg::GOAL_W-1:0] t_goal;
    typedef logic [hrc_pkg::ERR_W-1:0]         t_err;
    typedef logic [hrc_pkg::CFG_DW-1:0]        t_cfg_word;

    typedef struct {
        t_temp                     temp;
        t_temp                     tgt;
        logic [hrc_pkg::TIME_W-1:0] ms;
        bit                        pinned;
        hrc_pkg::t_result          res;
    } t_sample_row;

    logic                        i_clk     = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [hrc_pkg::IN_DW-1:0]   s_tdata   = '0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [hrc_pkg::OUT_DW-1:0]  m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [hrc_pkg::CFG_AW-1:0]  cfg_addr  = '0;
    logic [hrc_pkg::CFG_DW-1:0]  cfg_data  = '0;

    // predictor copy of the registers and the checker state
    logic [hrc_pkg::HYST_W-1:0] cfg_hyst;
    logic [hrc_pkg::MAXE_W-1:0] cfg_maxe;
    logic [hrc_pkg::GAIN_W-1:0] cfg_gain;
    logic [hrc_pkg::CGT_W-1:0]  cfg_window;
    bit                         heat_approach;
    bit                         heat_starting;
    t_temp                      prev_tgt;
    t_goal                      goal_level;
    logic [hrc_pkg::TIME_W-1:0] goal_deadline;
    t_err                       shortfall;
    bit                         fault_on;

    hrc_pkg::t_result pending_results[$];
    t_sample_row      dir_rows[$];
    bit               pin_on;
    hrc_pkg::t_result pin_res;
    int               errors;
    int               cycle_cnt;
    int               src_idle;
    int               sink_idle;
    int               hold_req;
    int               hold_left;
    int               random_sent;
    logic [hrc_pkg::TIME_W-1:0] clock_ms;
    t_temp                      cur_target;

    heater_runaway_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [hrc_pkg::TIME_W-1:0] window_close(
        logic [hrc_pkg::TIME_W-1:0] now);
        logic [63:0] sum;
        sum = {32'b0, now} + {44'b0, cfg_window};
        return (sum > 64'hFFFF_FFFF) ? '1 : sum[hrc_pkg::TIME_W-1:0];
    endfunction

    function automatic hrc_pkg::t_result predict_result(t_temp temp_in, t_temp tgt_in,
                                                        logic [hrc_pkg::TIME_W-1:0] now);
        int               temp;
        int               tgt;
        int               hy;
        int               gain;
        logic [63:0]      sum;
        bit               keep_target;
        hrc_pkg::t_result r;
        temp = temp_in;
        tgt  = tgt_in;
        hy   = int'(cfg_hyst);
        gain = int'(cfg_gain);
        r = '0;
        r.next_delay_s = hrc_pkg::DELAY_NORMAL;
        keep_target = 1'b1;
        if (temp >= tgt - hy || tgt <= 0) begin
            heat_approach = 1'b0;
            heat_starting = 1'b0;
            if (fault_on) begin
                fault_on = 1'b0;
                r.fault_cleared = 1'b1;
            end
            // above the band the shortfall sum is kept
            if (temp <= tgt + hy) begin
                shortfall = '0;
            end
            prev_tgt = t_temp'(tgt);
        end else begin
            sum = {32'b0, shortfall} + 64'((tgt - hy) - temp);
            shortfall = (sum > 64'hFFFF_FFFF) ? '1 : sum[hrc_pkg::ERR_W-1:0];
            if (!heat_approach) begin
                if (tgt != prev_tgt) begin
                    heat_approach = 1'b1;
                    heat_starting = 1'b1;
                    goal_level = t_goal'(temp + gain);
                    goal_deadline = window_close(now);
                end else if (shortfall >= cfg_maxe) begin
                    if (!fault_on) begin
                        fault_on = 1'b1;
                        r.fault_raised = 1'b1;
                        r.next_delay_s = hrc_pkg::DELAY_FAULT;
                        keep_target = 1'b0;
                    end else begin
                        shortfall = t_err'(cfg_maxe);
                    end
                end
            end else if (temp >= goal_level) begin
                heat_starting = 1'b0;
                shortfall = '0;
                goal_level = t_goal'(temp + gain);
                goal_deadline = window_close(now);
            end else if (now >= goal_deadline) begin
                heat_approach = 1'b0;
                if (fault_on) begin
                    fault_on = 1'b0;
                    r.fault_cleared = 1'b1;
                end
            end else if (heat_starting) begin
                if (temp + gain < goal_level) begin
                    goal_level = t_goal'(temp + gain);
                end
            end
            if (keep_target) begin
                prev_tgt = t_temp'(tgt);
            end
        end
        r.fault_active = fault_on;
        r.approaching  = heat_approach;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        hrc_pkg::t_result r;
        if (!rst_n) begin
            cfg_hyst      = hrc_pkg::HYST_RST;
            cfg_maxe      = hrc_pkg::MAXE_RST;
            cfg_gain      = hrc_pkg::GAIN_RST;
            cfg_window    = hrc_pkg::CGT_RST;
            heat_approach = 1'b0;
            heat_starting = 1'b0;
            prev_tgt      = '0;
            goal_level    = '0;
            goal_deadline = '1;
            shortfall     = '0;
            fault_on      = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    hrc_pkg::CFG_HYSTERESIS:  cfg_hyst   = cfg_data[hrc_pkg::HYST_W-1:0];
                    hrc_pkg::CFG_ERR_LIMIT:   cfg_maxe   = cfg_data[hrc_pkg::MAXE_W-1:0];
                    hrc_pkg::CFG_RISE_STEP:   cfg_gain   = cfg_data[hrc_pkg::GAIN_W-1:0];
                    hrc_pkg::CFG_RISE_WINDOW: cfg_window = cfg_data[hrc_pkg::CGT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                r = predict_result(s_tdata[13:0], s_tdata[27:14], s_tdata[59:28]);
                if (pin_on) begin
                    r = pin_res;
                end
                pending_results.push_back(r);
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result expected none actual %h", $time, m_tdata);
                end else begin
                    r = pending_results.pop_front();
                    check_field("fault_active", r.fault_active, m_tdata[0]);
                    check_field("fault_raised", r.fault_raised, m_tdata[1]);
                    check_field("fault_cleared", r.fault_cleared, m_tdata[2]);
                    check_field("approaching", r.approaching, m_tdata[3]);
                    check_field("next_delay_s", r.next_delay_s, m_tdata[5:4]);
                end
            end
        end
    end

    // sink side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("heater_runaway_checker_test: FAIL");
        $finish;
    end

    function automatic t_temp clamp_temp(int v);
        if (v > 8191) return 14'sd8191;
        if (v < -8192) return -14'sd8192;
        return t_temp'(v);
    endfunction

    function automatic void add_row(int temp, int tgt, logic [hrc_pkg::TIME_W-1:0] ms,
                                    bit pinned, logic [5:0] res);
        t_sample_row row;
        row.temp   = t_temp'(temp);
        row.tgt    = t_temp'(tgt);
        row.ms     = ms;
        row.pinned = pinned;
        row.res    = res;
        dir_rows.push_back(row);
    endfunction

    task automatic send_sample(t_temp temp, t_temp tgt, logic [hrc_pkg::TIME_W-1:0] ms,
                               bit pinned, hrc_pkg::t_result res);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ms, tgt, temp};
        pin_on  = pinned;
        pin_res = res;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [hrc_pkg::CFG_AW-1:0] idx, t_cfg_word val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic load_settings(int hy, int maxe, int gain, int window);
        drain();
        write_reg(hrc_pkg::CFG_HYSTERESIS, t_cfg_word'(hy));
        write_reg(hrc_pkg::CFG_ERR_LIMIT, t_cfg_word'(maxe));
        write_reg(hrc_pkg::CFG_RISE_STEP, t_cfg_word'(gain));
        write_reg(hrc_pkg::CFG_RISE_WINDOW, t_cfg_word'(window));
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // one heat-up attempt: fixed target, temperature ramping at a chosen rate
    task automatic heat_episode();
        int steps;
        int sel;
        int tgt;
        int temp;
        int lo;
        int hi;
        int g;
        steps = $urandom_range(60, 4);
        sel = $urandom_range(9);
        if (sel < 3) begin
            tgt = cur_target;
        end else if (sel == 3) begin
            tgt = -int'($urandom_range(8192));
        end else begin
            tgt = $urandom_range(8191, 1);
        end
        temp = clamp_temp(tgt - int'(cfg_hyst) - int'($urandom_range(3000)));
        g = cfg_gain;
        case ($urandom_range(2))
            0: begin
                lo = -2;
                hi = 2;
            end
            1: begin
                lo = 0;
                hi = g / 4 + 1;
            end
            default: begin
                lo = g / 2;
                hi = 2 * g;
            end
        endcase
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(19) == 0) begin
                temp = clamp_temp(int'($urandom_range(16383)) - 8192);
            end else begin
                temp = clamp_temp(temp + lo + int'($urandom_range(hi - lo)));
            end
            clock_ms += 1000 + $urandom_range(30);
            if ($urandom_range(29) == 0) begin
                clock_ms += cfg_window;
            end
            send_sample(t_temp'(temp), t_temp'(tgt), clock_ms, 1'b0, '0);
            random_sent++;
        end
        cur_target = t_temp'(tgt);
    endtask

    task automatic noise_sample();
        logic [hrc_pkg::TIME_W-1:0] ms;
        case ($urandom_range(3))
            0: ms = $urandom;
            1: begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(100000);
                ms = clock_ms;
            end
            default: ms = clock_ms;
        endcase
        send_sample(t_temp'($urandom), t_temp'($urandom), ms, 1'b0, '0);
        random_sent++;
    endtask

    task automatic run_segment(int n);
        random_sent = 0;
        while (random_sent < n) begin
            if ($urandom_range(9) == 0) begin
                noise_sample();
            end else begin
                heat_episode();
            end
        end
    endtask

    initial begin
        src_idle  = 11;
        sink_idle = 51;
        clock_ms  = '0;
        cur_target = 1000;
        // fault_active, fault_raised, fault_cleared, approaching, next_delay_s
        add_row(0,     0,     32'd0,     1'b1, {4'b0000, hrc_pkg::DELAY_NORMAL});
        add_row(-8192, 8191,  32'd1000,  1'b1, {4'b0001, hrc_pkg::DELAY_NORMAL});
        add_row(-8192, 8191,  32'd2000,  1'b0, '0);
        add_row(-8192, 8191,  32'd21000, 1'b0, '0);
        add_row(-8192, 8191,  32'd22000, 1'b1, {4'b1100, hrc_pkg::DELAY_FAULT});
        add_row(-8192, 8191,  32'd23000, 1'b1, {4'b1000, hrc_pkg::DELAY_NORMAL});
        add_row(8191,  8191,  32'd24000, 1'b1, {4'b0010, hrc_pkg::DELAY_NORMAL});
        add_row(-100,  -8192, 32'd25000, 1'b1, {4'b0000, hrc_pkg::DELAY_NORMAL});
        add_row(0,     1000,  32'd26000, 1'b0, '0);
        add_row(-50,   1000,  32'd27000, 1'b0, '0);
        add_row(-18,   1000,  32'd28000, 1'b0, '0);
        add_row(8191,  1000,  32'd29000, 1'b0, '0);
        add_row(0,     1000,  32'd30000, 1'b0, '0);
        add_row(0,     1000,  32'd31000, 1'b0, '0);
        add_row(0,     1000,  32'd32000, 1'b0, '0);
        add_row(100,   2000,  32'hFFFF_C000, 1'b0, '0);
        add_row(100,   2000,  32'hFFFF_F000, 1'b0, '0);
        add_row(100,   2000,  32'd5,     1'b0, '0);
        add_row(100,   2000,  32'hFFFF_FFFF, 1'b0, '0);
        add_row(920,   1000,  32'd40000, 1'b0, '0);
        add_row(919,   1000,  32'd41000, 1'b0, '0);
        add_row(1080,  1000,  32'd42000, 1'b0, '0);
        add_row(8191,  -1,    32'd43000, 1'b0, '0);

        repeat (7) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            send_sample(dir_rows[i].temp, dir_rows[i].tgt, dir_rows[i].ms,
                        dir_rows[i].pinned, dir_rows[i].res);
        end

        load_settings(80, 1920, 32, 20000);
        run_segment(SEG_ITEMS);
        load_settings(0, 0, 1, 1000);
        run_segment(SEG_ITEMS);

        src_idle  = 51;
        sink_idle = 11;
        load_settings(1600, 1048575, 1600, 600000);
        run_segment(SEG_ITEMS);
        load_settings(16, 300, 8, 3000);
        run_segment(SEG_ITEMS);

        src_idle  = 0;
        sink_idle = 0;
        load_settings($urandom_range(1600), $urandom_range(20000), $urandom_range(1600, 1),
                      $urandom_range(600000, 1000));
        hold_req = 300;
        run_segment(SEG_ITEMS);
        load_settings(40, 5000, 64, 10000);
        run_segment(SEG_ITEMS);

        drain();
        if (errors == 0) begin
            $display("heater_runaway_checker_test: PASS");
        end else begin
            $display("heater_runaway_checker_test: FAIL");
        end
        $finish;
    end

endmodule
